// File: rtl/interval_table_lookup_core_assert.svh
// assertion macros shared by the interval table lookup checker
// no dependencies
`ifndef INTERVAL_TABLE_LOOKUP_CORE_ASSERT_SVH
`define INTERVAL_TABLE_LOOKUP_CORE_ASSERT_SVH

`define ITL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itl assertion failed");

`define ITL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itl assertion failed");

`endif

// File: rtl/itl_pkg.sv
// types and constants for the interval table lookup core
// no dependencies
`default_nettype none
package itl_pkg;
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_SEARCH = 2'd2;
   localparam logic [1:0] MODE_KEEP = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [63:0] LIMIT_LOW = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] FILL_LOW = 64'h0000_0000_FFFF_FFFE;
   localparam logic [63:0] FILL_HIGH = 64'hFFFF_FFFF_FFFF_FFFE;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] entry_start;
      logic [63:0] entry_end;
      logic [62:0] entry_payload;
      logic [63:0] lookup_addr;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  hit_index;
      logic [63:0] hit_start;
      logic [63:0] hit_end;
      logic [62:0] hit_payload;
   } rsp_type;

   typedef struct packed {
      logic        keep;
      logic [62:0] payload;
      logic [63:0] stop;
      logic [63:0] start;
   } entry_type;
endpackage
`default_nettype wire

// File: rtl/interval_table_lookup_core.sv
// Interval table lookup core. One transaction at a time; req_stall is high while a
// transaction is in work. A search is a binary search over the sorted table. A
// build sorts the table in place by insertion sort on entry start over the table
// memory (one read port, one write port), then a fill pass sets each open entry
// end to the next entry's start. Depends on itl_pkg.
`default_nettype none
module interval_table_lookup_core #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire itl_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output itl_pkg::rsp_type     rsp_data
);
   import itl_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SORT_RI = 4'd1;
   localparam logic [3:0] ST_SORT_KI = 4'd2;
   localparam logic [3:0] ST_SORT_RJ = 4'd3;
   localparam logic [3:0] ST_SORT_CJ = 4'd4;
   localparam logic [3:0] ST_FILL_RA = 4'd5;
   localparam logic [3:0] ST_FILL_RB = 4'd6;
   localparam logic [3:0] ST_FILL_C = 4'd7;
   localparam logic [3:0] ST_LAST_R = 4'd8;
   localparam logic [3:0] ST_LAST_C = 4'd9;
   localparam logic [3:0] ST_MIN_R = 4'd10;
   localparam logic [3:0] ST_MIN_C = 4'd11;
   localparam logic [3:0] ST_SRCH_R = 4'd12;
   localparam logic [3:0] ST_SRCH_C = 4'd13;
   localparam logic [3:0] ST_DONE = 4'd14;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;
   entry_type wr_data;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] mid_c;
   logic [AW-1:0] mid_ff, mid_in;
   logic built_ff, built_in;
   logic [63:0] rmin_ff, rmin_in, rmax_ff, rmax_in, addr_ff, addr_in, last_end;
   logic keep_ff, keep_in;
   entry_type key_ff, key_in;
   rsp_type res_ff, res_in, rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] load_idx;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign mid_c = lo_ff + ((hi_ff - ONE_C - lo_ff) >> 1);
   assign load_idx = built_ff ? '0 : cnt_ff;
   assign last_end = (rd_ff.stop != 64'd0) ? rd_ff.stop :
                     ((rd_ff.start < LIMIT_LOW) ? FILL_LOW : FILL_HIGH);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      i_in = i_ff;
      j_in = j_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      built_in = built_ff;
      rmin_in = rmin_ff;
      rmax_in = rmax_ff;
      addr_in = addr_ff;
      keep_in = keep_ff;
      key_in = key_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr = '0;
      wr_addr = '0;
      wr_en = 1'b0;
      wr_data = key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               addr_in = req_data.lookup_addr;
               keep_in = (req_data.mode == MODE_KEEP);
               unique case (req_data.mode)
                  MODE_LOAD: begin
                     state_in = ST_DONE;
                     built_in = 1'b0;
                     if (load_idx >= DEPTH_C) begin
                        cnt_in = load_idx;
                        res_in.status = STATUS_FULL;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = load_idx[AW-1:0];
                        wr_data.start = req_data.entry_start;
                        wr_data.stop = req_data.entry_end;
                        wr_data.payload = req_data.entry_payload;
                        wr_data.keep = 1'b0;
                        cnt_in = load_idx + ONE_C;
                     end
                  end
                  MODE_BUILD: begin
                     built_in = 1'b1;
                     i_in = ONE_C;
                     if (cnt_ff == '0) begin
                        rmin_in = '0;
                        rmax_in = '0;
                        state_in = ST_DONE;
                     end else if (cnt_ff > ONE_C) begin
                        state_in = ST_SORT_RI;
                     end else begin
                        state_in = ST_LAST_R;
                     end
                  end
                  MODE_SEARCH, MODE_KEEP: begin
                     res_in.status = STATUS_MISS;
                     lo_in = '0;
                     hi_in = cnt_ff;
                     if (!built_ff || cnt_ff == '0 || req_data.lookup_addr < rmin_ff ||
                         req_data.lookup_addr > rmax_ff) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SRCH_R;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SORT_RI: begin
            rd_addr = i_ff[AW-1:0];
            state_in = ST_SORT_KI;
         end
         ST_SORT_KI: begin
            key_in = rd_ff;
            j_in = i_ff;
            state_in = ST_SORT_RJ;
         end
         ST_SORT_RJ: begin
            rd_addr = AW'(j_ff - ONE_C);
            if (j_ff == '0) begin
               wr_en = 1'b1;
               wr_addr = '0;
               i_in = i_ff + ONE_C;
               state_in = (i_ff + ONE_C < cnt_ff) ? ST_SORT_RI : ST_FILL_RA;
               i_in = (i_ff + ONE_C < cnt_ff) ? i_ff + ONE_C : '0;
            end else begin
               state_in = ST_SORT_CJ;
            end
         end
         ST_SORT_CJ: begin
            wr_en = 1'b1;
            wr_addr = j_ff[AW-1:0];
            if (rd_ff.start > key_ff.start) begin
               wr_data = rd_ff;
               j_in = j_ff - ONE_C;
               state_in = ST_SORT_RJ;
            end else begin
               state_in = (i_ff + ONE_C < cnt_ff) ? ST_SORT_RI : ST_FILL_RA;
               i_in = (i_ff + ONE_C < cnt_ff) ? i_ff + ONE_C : '0;
            end
         end
         ST_FILL_RA: begin
            rd_addr = i_ff[AW-1:0];
            state_in = ST_FILL_RB;
         end
         ST_FILL_RB: begin
            key_in = rd_ff;
            rd_addr = AW'(i_ff + ONE_C);
            state_in = ST_FILL_C;
         end
         ST_FILL_C: begin
            if (key_ff.stop == 64'd0) begin
               wr_en = 1'b1;
               wr_addr = i_ff[AW-1:0];
               wr_data.stop = rd_ff.start;
            end
            i_in = i_ff + ONE_C;
            state_in = (i_ff + ONE_C + ONE_C < cnt_ff) ? ST_FILL_RA : ST_LAST_R;
         end
         ST_LAST_R: begin
            rd_addr = AW'(cnt_ff - ONE_C);
            state_in = ST_LAST_C;
         end
         ST_LAST_C: begin
            wr_en = 1'b1;
            wr_addr = AW'(cnt_ff - ONE_C);
            wr_data = rd_ff;
            wr_data.stop = last_end;
            rmax_in = last_end;
            state_in = ST_MIN_R;
         end
         ST_MIN_R: begin
            rd_addr = '0;
            state_in = ST_MIN_C;
         end
         ST_MIN_C: begin
            rmin_in = rd_ff.start;
            state_in = ST_DONE;
         end
         ST_SRCH_R: begin
            rd_addr = mid_c[AW-1:0];
            mid_in = mid_c[AW-1:0];
            state_in = ST_SRCH_C;
         end
         ST_SRCH_C: begin
            if (addr_ff >= rd_ff.start && addr_ff < rd_ff.stop) begin
               res_in.status = STATUS_OK;
               res_in.hit_index = 10'(mid_ff);
               res_in.hit_start = rd_ff.start;
               res_in.hit_end = rd_ff.stop;
               res_in.hit_payload = rd_ff.payload;
               if (keep_ff) begin
                  wr_en = 1'b1;
                  wr_addr = mid_ff;
                  wr_data = rd_ff;
                  wr_data.keep = 1'b1;
               end
               state_in = ST_DONE;
            end else if (addr_ff < rd_ff.start) begin
               hi_in = CW'(mid_ff);
               state_in = (lo_ff < CW'(mid_ff)) ? ST_SRCH_R : ST_DONE;
            end else begin
               lo_in = CW'(mid_ff) + ONE_C;
               state_in = (CW'(mid_ff) + ONE_C < hi_ff) ? ST_SRCH_R : ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         built_ff <= 1'b0;
         rmin_ff <= '0;
         rmax_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         built_ff <= built_in;
         rmin_ff <= rmin_in;
         rmax_ff <= rmax_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      addr_ff <= addr_in;
      keep_ff <= keep_in;
      key_ff <= key_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

// File: rtl/itl_checker.sv
// port-level checker for the interval table lookup core, bound to the core module
// depends on itl_pkg and interval_table_lookup_core_assert.svh
`default_nettype none
`include "interval_table_lookup_core_assert.svh"
module itl_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire itl_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire itl_pkg::rsp_type rsp_data
);
   import itl_pkg::*;

   logic req_acc, rsp_acc, miss, full, hit_zero;
   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign miss = rsp_valid && rsp_data.status == STATUS_MISS;
   assign full = rsp_valid && rsp_data.status == STATUS_FULL;
   assign hit_zero = rsp_data.hit_start == 64'd0 && rsp_data.hit_end == 64'd0 &&
                     rsp_data.hit_index == 10'd0;

   `ITL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_acc, req_stall)
   `ITL_ASSERT_IMPL(a_status_legal, clock, reset, rsp_valid, rsp_data.status != 2'd3)
   `ITL_ASSERT_IMPL(a_miss_zero, clock, reset, miss || full, hit_zero)
   `ITL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `ITL_ASSERT_NEXT(a_no_rsp_idle, clock, reset, rsp_acc && !req_stall && !req_valid, !rsp_valid)
endmodule

bind interval_table_lookup_core itl_checker u_itl_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire
